// File: sv/uripn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uripn_pkg: shared types and constants for the URI path normalizer
// Buffer sizes, derived widths, status and dot-segment codes, and the bytes
// the parser treats specially.
// ----------------------------------------------------------------------------
package uripn_pkg;

    localparam int MAX_PATH_BYTES = 1024;
    localparam int MAX_SEGMENTS   = 256;

    localparam int PATH_AW = $clog2(MAX_PATH_BYTES);
    localparam int WP_W    = $clog2(MAX_PATH_BYTES + 1);
    localparam int SEG_AW  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);

    localparam int IDX_W   = 10;
    localparam int LEN_W   = 11;
    localparam int IN_DW   = 24;
    localparam int OUT_DW  = 24;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_PRINT_LO  = 8'h20;
    localparam logic [7:0] CH_DEL       = 8'h7F;

    typedef enum logic [1:0] {
        ST_BUSY   = 2'd0,
        ST_VALID  = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        DOT_NONE = 2'd0,
        DOT_ONE  = 2'd1,
        DOT_TWO  = 2'd2,
        DOT_ORD  = 2'd3
    } t_dot_kind;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        HEX_IDLE = 2'd0,
        HEX_LOW  = 2'd1,
        HEX_HIGH = 2'd2
    } t_hex_pend;

endpackage

// File: sv/uri_path_normalizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uri_path_normalizer_top: streaming URI path dot-segment removal
//
// Slave stream: one item per beat. tuser is the command (push a path byte or
// read a result byte), tlast marks the final byte of a path on a push, tdata
// carries the path byte and the read index. Each item gives exactly one
// result item on the master stream: status, normalized length, read byte.
//
// The path is parsed byte by byte: slashes collapse, "." segments drop, ".."
// pops the segment stack, bad bytes and bad escapes reject the path. The
// normalized path stays in a 1024-byte buffer that read commands fetch.
//
// A result passes the status register, then the output register, before it
// appears on the master side. Throughput is one item per cycle; the path
// buffer and segment stack each take at most one access per item, and the
// stack top is held in a register that refills from the stack RAM in the
// cycle after a pop. When the master side stalls, the two result stages fill
// and then tready drops; nothing is lost. Reset clears the parser to await a
// new path and empties the pipeline; buffer contents are not cleared.
// ----------------------------------------------------------------------------
module uri_path_normalizer_top
    import uripn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_DW-1:0]  i_s_tdata,   // [7:0] data_byte, [17:8] read_index
    input  logic              i_s_tuser,   // [0] command
    input  logic              i_s_tlast,   // last byte of the path
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_DW-1:0] o_m_tdata    // [1:0] status, [12:2] path_length,
                                           // [20:13] read_byte
);

    // parser state
    logic [WP_W-1:0]    r_wp, n_wp;
    logic [PATH_AW-1:0] r_cur, n_cur;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_inside, n_inside;
    t_dot_kind          r_dot, n_dot;
    t_hex_pend          r_hexp, n_hexp;
    logic [3:0]         r_hexhi, n_hexhi;
    logic               r_first, n_first;
    logic               r_rej, n_rej;
    logic [WP_W-1:0]    r_final, n_final;

    // memories and stack top
    logic [7:0]         r_path_mem [MAX_PATH_BYTES];
    logic [PATH_AW-1:0] r_seg_mem  [MAX_SEGMENTS];
    logic [7:0]         r_rd_q;
    logic [PATH_AW-1:0] r_seg_q;
    logic [PATH_AW-1:0] r_top;
    logic               r_top_pend;
    logic [PATH_AW-1:0] top;

    // pipeline
    logic               r_a_valid;
    t_status            r_a_status;
    logic [WP_W-1:0]    r_a_len;
    logic               r_a_rdok;
    logic               r_b_valid;
    logic [OUT_DW-1:0]  r_b_data;

    logic               s_acc, acc_push, acc_read, a_move;
    logic [7:0]         din;
    logic [IDX_W-1:0]   idx;
    logic               last;

    t_status            st;
    logic               fail, do_end, wp_full;
    logic               pw_en;
    logic [PATH_AW-1:0] pw_addr;
    logic [7:0]         pw_data;
    logic               sg_push, sg_pop;
    logic [SEG_AW-1:0]  sg_raddr;
    logic [4:0]         hex_n;
    t_dot_kind          base;

    t_status            rd_st;
    logic               rd_ok;
    logic [7:0]         rd_byte;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
        return 5'd0;
    endfunction

    function automatic logic bad_escape(input logic [7:0] d);
        return (d < CH_PRINT_LO) || (d >= CH_DEL) || (d == CH_SLASH) ||
               (d == CH_BACKSLASH) || (d == CH_DOT) || (d == CH_PERCENT);
    endfunction

    // drop a trailing slash unless the path is the root
    function automatic logic [WP_W-1:0] trim(input logic [WP_W-1:0] v);
        return (v > WP_W'(1)) ? v - WP_W'(1) : v;
    endfunction

    assign din  = i_s_tdata[7:0];
    assign idx  = i_s_tdata[8 +: IDX_W];
    assign last = i_s_tlast;

    assign a_move     = r_a_valid && (!r_b_valid || i_m_tready);
    assign o_s_tready = !r_a_valid || a_move;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign acc_push   = s_acc && (t_cmd'(i_s_tuser) == CMD_PUSH);
    assign acc_read   = s_acc && (t_cmd'(i_s_tuser) == CMD_READ);

    assign top      = r_top_pend ? r_seg_q : r_top;
    assign wp_full  = r_wp >= WP_W'(MAX_PATH_BYTES);
    assign hex_n    = hex_decode(din);
    assign sg_raddr = SEG_AW'(r_cnt - CNT_W'(2));

    always_comb begin
        n_wp     = r_wp;
        n_cur    = r_cur;
        n_cnt    = r_cnt;
        n_inside = r_inside;
        n_dot    = r_dot;
        n_hexp   = r_hexp;
        n_hexhi  = r_hexhi;
        n_first  = r_first;
        n_rej    = r_rej;
        n_final  = r_final;
        st       = ST_BUSY;
        fail     = 1'b0;
        do_end   = 1'b0;
        pw_en    = 1'b0;
        pw_addr  = r_wp[PATH_AW-1:0];
        pw_data  = din;
        sg_push  = 1'b0;
        sg_pop   = 1'b0;
        base     = r_inside ? r_dot : DOT_NONE;

        if (r_first) begin
            // start a new path
            n_first  = 1'b0;
            n_rej    = 1'b0;
            n_final  = '0;
            n_wp     = '0;
            n_cur    = '0;
            n_cnt    = '0;
            n_inside = 1'b0;
            n_dot    = DOT_NONE;
            n_hexp   = HEX_IDLE;
            n_hexhi  = '0;
            if (din != CH_SLASH) begin
                fail = 1'b1;
            end else begin
                pw_en   = 1'b1;
                pw_addr = '0;
                pw_data = CH_SLASH;
                n_wp    = WP_W'(1);
                if (last) begin
                    n_final = WP_W'(1);
                    n_first = 1'b1;
                    st      = ST_VALID;
                end
            end
        end else if (r_rej) begin
            fail = 1'b1;
        end else if (r_hexp != HEX_IDLE) begin
            if (!hex_n[4]) begin
                fail = 1'b1;
            end else if (r_hexp == HEX_HIGH) begin
                n_hexhi = hex_n[3:0];
                n_hexp  = HEX_LOW;
            end else if (bad_escape({r_hexhi, hex_n[3:0]})) begin
                fail = 1'b1;
            end else begin
                n_hexp = HEX_IDLE;
            end
            if (!fail) begin
                if (wp_full) begin
                    fail = 1'b1;
                end else begin
                    pw_en = 1'b1;
                    n_wp  = r_wp + WP_W'(1);
                end
            end
            do_end = last;
        end else if (din == CH_SLASH) begin
            if (r_inside) begin
                n_inside = 1'b0;
                case (r_dot)
                    DOT_ONE: n_wp = WP_W'(r_cur);
                    DOT_TWO: begin
                        if (r_cnt == '0) begin
                            fail = 1'b1;
                        end else begin
                            sg_pop = 1'b1;
                            n_cnt  = r_cnt - CNT_W'(1);
                            n_wp   = WP_W'(top);
                        end
                    end
                    default: begin
                        if (r_cnt >= CNT_W'(MAX_SEGMENTS)) begin
                            fail = 1'b1;
                        end else begin
                            sg_push = 1'b1;
                            n_cnt   = r_cnt + CNT_W'(1);
                            if (wp_full) begin
                                fail = 1'b1;
                            end else begin
                                pw_en   = 1'b1;
                                pw_data = CH_SLASH;
                                n_wp    = r_wp + WP_W'(1);
                            end
                        end
                    end
                endcase
            end
            if (!fail && last) begin
                n_final = trim(n_wp);
                n_first = 1'b1;
                st      = ST_VALID;
            end
        end else begin
            if (din < CH_PRINT_LO || din >= CH_DEL || din == CH_BACKSLASH) begin
                fail = 1'b1;
            end else begin
                if (!r_inside) begin
                    n_inside = 1'b1;
                    n_cur    = r_wp[PATH_AW-1:0];
                end
                if (wp_full) begin
                    fail = 1'b1;
                end else begin
                    pw_en = 1'b1;
                    n_wp  = r_wp + WP_W'(1);
                    if (din == CH_DOT && base == DOT_NONE) begin
                        n_dot = DOT_ONE;
                    end else if (din == CH_DOT && base == DOT_ONE) begin
                        n_dot = DOT_TWO;
                    end else begin
                        n_dot = DOT_ORD;
                    end
                    if (din == CH_PERCENT) begin
                        n_hexp = HEX_HIGH;
                    end
                end
            end
            do_end = last;
        end

        // close the open segment at the end of the path
        if (do_end && !fail) begin
            if (n_hexp != HEX_IDLE) begin
                fail = 1'b1;
            end else begin
                n_inside = 1'b0;
                case (n_dot)
                    DOT_ONE: begin
                        n_wp    = WP_W'(n_cur);
                        n_final = trim(WP_W'(n_cur));
                    end
                    DOT_TWO: begin
                        if (r_cnt == '0) begin
                            fail = 1'b1;
                        end else begin
                            sg_pop  = 1'b1;
                            n_cnt   = r_cnt - CNT_W'(1);
                            n_wp    = WP_W'(top);
                            n_final = trim(WP_W'(top));
                        end
                    end
                    default: begin
                        if (r_cnt >= CNT_W'(MAX_SEGMENTS)) begin
                            fail = 1'b1;
                        end else begin
                            sg_push = 1'b1;
                            n_cnt   = r_cnt + CNT_W'(1);
                            n_final = n_wp;
                        end
                    end
                endcase
                if (!fail) begin
                    n_first = 1'b1;
                    st      = ST_VALID;
                end
            end
        end

        if (fail) begin
            n_rej   = 1'b1;
            n_final = '0;
            if (last) begin
                n_first = 1'b1;
            end
            st      = ST_REJECT;
            pw_en   = 1'b0;
            sg_push = 1'b0;
            sg_pop  = 1'b0;
        end
    end

    // read command: status and range check against the finished path
    always_comb begin
        if (r_first && r_rej) begin
            rd_st = ST_REJECT;
        end else if (r_first && r_final != '0) begin
            rd_st = ST_VALID;
        end else begin
            rd_st = ST_BUSY;
        end
        rd_ok = (WP_W'(idx) < r_final) && (32'(idx) < 32'(MAX_PATH_BYTES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_cur    <= '0;
            r_cnt    <= '0;
            r_inside <= 1'b0;
            r_dot    <= DOT_NONE;
            r_hexp   <= HEX_IDLE;
            r_hexhi  <= '0;
            r_first  <= 1'b1;
            r_rej    <= 1'b0;
            r_final  <= '0;
        end else if (acc_push) begin
            r_wp     <= n_wp;
            r_cur    <= n_cur;
            r_cnt    <= n_cnt;
            r_inside <= n_inside;
            r_dot    <= n_dot;
            r_hexp   <= n_hexp;
            r_hexhi  <= n_hexhi;
            r_first  <= n_first;
            r_rej    <= n_rej;
            r_final  <= n_final;
        end
    end

    // path buffer: one write for a push, one registered read for a read command
    always_ff @(posedge i_clk) begin
        if (acc_push && pw_en) begin
            r_path_mem[pw_addr] <= pw_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_read) begin
            r_rd_q <= r_path_mem[PATH_AW'(idx)];
        end
    end

    // segment stack: push writes, pop fetches the entry that becomes the new top
    always_ff @(posedge i_clk) begin
        if (acc_push && sg_push) begin
            r_seg_mem[r_cnt[SEG_AW-1:0]] <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_push && sg_pop) begin
            r_seg_q <= r_seg_mem[sg_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_push && sg_push) begin
            r_top <= n_cur;
        end else if (r_top_pend) begin
            r_top <= r_seg_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_pend <= 1'b0;
        end else begin
            r_top_pend <= acc_push && sg_pop;
        end
    end

    // status stage, then output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_push) begin
            r_a_status <= st;
            r_a_len    <= (st == ST_VALID) ? n_final : '0;
            r_a_rdok   <= 1'b0;
        end else if (acc_read) begin
            r_a_status <= rd_st;
            r_a_len    <= r_final;
            r_a_rdok   <= rd_ok;
        end
    end

    assign rd_byte = r_a_rdok ? r_rd_q : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_move) begin
            r_b_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_data <= {3'b000, rd_byte, LEN_W'(r_a_len), r_a_status};
        end
    end

    assign o_m_tvalid = r_b_valid;
    assign o_m_tdata  = r_b_data;

    // checks
    a_cnt_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count beyond stack depth");

    a_wp_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= WP_W'(MAX_PATH_BYTES))
        else $error("write position beyond buffer");

    a_pop_refill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_push && sg_pop) |=> r_top_pend)
        else $error("stack top not refilled after pop");

    a_hex_inside : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hexp != HEX_IDLE) |-> r_inside)
        else $error("escape pending outside a segment");

    a_no_overrun : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_b_valid && !i_m_tready) |-> !o_s_tready)
        else $error("item accepted with both result stages full");

endmodule
